@@ sv/smc_pkg.sv @@
// Shared types, codes and bit-mapping helpers for the SPI master controller.
// No dependencies; smc_core and spi_master_controller_top import this package.
`default_nettype none

package smc_pkg;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [3:0] ADDR_TRANS    = 4'd0;
  localparam logic [3:0] ADDR_OPCODE   = 4'd1;
  localparam logic [3:0] ADDR_DATA0    = 4'd2;
  localparam logic [3:0] ADDR_BITCOUNT = 4'd11;
  localparam logic [3:0] ADDR_POLARITY = 4'd14;

  localparam logic [3:0] CFG_CLOCK_DIVIDER  = 4'd0;
  localparam logic [3:0] CFG_CLOCK_POLARITY = 4'd1;
  localparam logic [3:0] CFG_CLOCK_PHASE    = 4'd2;
  localparam logic [3:0] CFG_LSB_FIRST      = 4'd3;

  localparam int START_BIT = 8;
  localparam int BUSY_BIT  = 16;
  localparam int CMD_MAX   = 32;

  typedef struct packed {
    logic [11:0] clock_divider;
    logic        clock_polarity;
    logic        clock_phase;
    logic        lsb_first;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  word_address;
    logic [31:0] write_data;
    logic        miso_pin;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        sclk_pin;
    logic        mosi_pin;
    logic [7:0]  chip_select_lines;
    logic        busy_flag;
  } res_t;

  // bit position inside a 32-bit data word for stream bit k (low byte first)
  function automatic logic [4:0] data_bit_pos(input logic [4:0] k, input logic lsb);
    return {k[4:3], (lsb ? k[2:0] : ~k[2:0])};
  endfunction

  // bit position inside the opcode word for command bit k (top byte first)
  function automatic logic [4:0] cmd_bit_pos(input logic [4:0] k, input logic lsb);
    return {~k[4:3], (lsb ? k[2:0] : ~k[2:0])};
  endfunction

endpackage

`default_nettype wire

@@ sv/smc_request_if.sv @@
// Request channel: one system tick with an optional bus access and MISO sample.
// No dependencies.
`default_nettype none

interface smc_request_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [3:0]  word_address;
  logic [31:0] write_data;
  logic        miso_pin;

  modport source(output valid, output mode, output word_address, output write_data,
                 output miso_pin, input ready);
  modport sink(input valid, input mode, input word_address, input write_data,
               input miso_pin, output ready);
endinterface

`default_nettype wire

@@ sv/smc_result_if.sv @@
// Result channel: bus read data and the serial pin levels after one tick.
// No dependencies.
`default_nettype none

interface smc_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        sclk_pin;
  logic        mosi_pin;
  logic [7:0]  chip_select_lines;
  logic        busy_flag;

  modport source(output valid, output read_data, output sclk_pin, output mosi_pin,
                 output chip_select_lines, output busy_flag, input ready);
  modport sink(input valid, input read_data, input sclk_pin, input mosi_pin,
               input chip_select_lines, input busy_flag, output ready);
endinterface

`default_nettype wire

@@ sv/smc_cfg_if.sv @@
// Configuration write channel: register index and write data.
// No dependencies.
`default_nettype none

interface smc_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/smc_core.sv @@
// Register file and serial engine of the SPI master; advances one tick per request.
// Depends on smc_pkg.
`default_nettype none

module smc_core
  import smc_pkg::*;
#(
  parameter int DATA_WORDS = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic accept,
  input  wire req_t req,
  input  wire cfg_t cfg,
  output res_t      result
);

  localparam int WIDX     = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int TOTW_RAW = $clog2(CMD_MAX + 64 * DATA_WORDS + 1);
  localparam int TOTW     = (TOTW_RAW < 10) ? 10 : TOTW_RAW;
  localparam logic [TOTW-1:0] DATA_MAX = TOTW'(32 * DATA_WORDS);
  localparam logic [4:0] DW5 = 5'(DATA_WORDS);

  logic [31:0]     opcode_word;
  logic [31:0]     data_words [DATA_WORDS];
  logic [5:0]      command_bit_count;
  logic [8:0]      mosi_bit_count;
  logic [8:0]      miso_bit_count;
  logic [7:0]      polarity_bits;
  logic            busy;
  logic [TOTW-1:0] bit_position;
  logic [12:0]     tick_counter;

  logic            busy_next;
  logic [TOTW-1:0] bit_position_next;
  logic [12:0]     tick_counter_next;

  logic [TOTW-1:0] n_cmd, n_mosi, n_miso, n_head, n_total;
  logic [12:0]     period, tick_inc;
  logic [11:0]     half;
  logic            data_hit;
  logic [WIDX-1:0] addr_idx;
  logic [TOTW-1:0] rx_k, tx_k;
  logic [WIDX-1:0] rx_word, tx_word;
  logic            capture;
  logic            start;
  logic            wr_en, wr_idle;
  logic [31:0]     read_value;

  always_comb begin
    n_cmd  = (command_bit_count > 6'(CMD_MAX)) ? TOTW'(CMD_MAX) : TOTW'(command_bit_count);
    n_mosi = (TOTW'(mosi_bit_count) > DATA_MAX) ? DATA_MAX : TOTW'(mosi_bit_count);
    n_miso = (TOTW'(miso_bit_count) > DATA_MAX) ? DATA_MAX : TOTW'(miso_bit_count);
    n_head = n_cmd + n_mosi;
    n_total = n_head + n_miso;
    period = {1'b0, cfg.clock_divider} + 13'd2;
    half = period[12:1];
    tick_inc = tick_counter + 13'd1;
  end

  assign data_hit = (req.word_address >= ADDR_DATA0)
                 && ({1'b0, req.word_address - ADDR_DATA0} < DW5);
  assign addr_idx = WIDX'(req.word_address - ADDR_DATA0);
  assign wr_en = accept && (req.mode == MODE_WRITE);
  assign wr_idle = wr_en && !busy;
  assign start = wr_idle && (req.word_address == ADDR_TRANS)
              && req.write_data[START_BIT] && (n_total != '0);

  assign rx_k = bit_position - n_head;
  assign rx_word = WIDX'(rx_k >> 5);
  assign capture = accept && busy && ({1'b0, half} == tick_counter)
                && (bit_position >= n_head) && (bit_position < n_total);

  always_comb begin
    busy_next = busy;
    bit_position_next = bit_position;
    tick_counter_next = tick_counter;
    if (busy) begin
      tick_counter_next = tick_inc;
      if (tick_inc >= period) begin
        tick_counter_next = '0;
        bit_position_next = bit_position + 1'b1;
        if (bit_position + 1'b1 >= n_total) begin
          busy_next = 1'b0;
          bit_position_next = '0;
        end
      end
    end else if (start) begin
      busy_next = 1'b1;
      bit_position_next = '0;
      tick_counter_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      opcode_word <= '0;
      for (int i = 0; i < DATA_WORDS; i++) begin
        data_words[i] <= '0;
      end
      command_bit_count <= '0;
      mosi_bit_count <= '0;
      miso_bit_count <= '0;
      polarity_bits <= '0;
      busy <= 1'b0;
      bit_position <= '0;
      tick_counter <= '0;
    end else begin
      if (accept) begin
        busy <= busy_next;
        bit_position <= bit_position_next;
        tick_counter <= tick_counter_next;
      end
      if (wr_en && req.word_address == ADDR_POLARITY) begin
        polarity_bits <= req.write_data[7:0];
      end else if (wr_idle) begin
        priority if (req.word_address == ADDR_OPCODE) begin
          opcode_word <= req.write_data;
        end else if (data_hit) begin
          data_words[addr_idx] <= req.write_data;
        end else if (req.word_address == ADDR_BITCOUNT) begin
          command_bit_count <= req.write_data[29:24];
          miso_bit_count <= req.write_data[20:12];
          mosi_bit_count <= req.write_data[8:0];
        end
      end
      if (capture) begin
        data_words[rx_word][data_bit_pos(rx_k[4:0], cfg.lsb_first)] <= req.miso_pin;
      end
    end
  end

  always_comb begin
    read_value = '0;
    if (req.mode == MODE_READ) begin
      priority if (req.word_address == ADDR_TRANS) begin
        read_value[BUSY_BIT] = busy;
      end else if (req.word_address == ADDR_OPCODE) begin
        read_value = opcode_word;
      end else if (data_hit) begin
        read_value = data_words[addr_idx];
      end else if (req.word_address == ADDR_BITCOUNT) begin
        read_value = {2'b00, command_bit_count, 3'b000, miso_bit_count,
                      3'b000, mosi_bit_count};
      end else if (req.word_address == ADDR_POLARITY) begin
        read_value = {24'd0, polarity_bits};
      end
    end
  end

  function automatic logic [7:0] polarity_bits_after();
    return (wr_en && req.word_address == ADDR_POLARITY) ? req.write_data[7:0]
                                                        : polarity_bits;
  endfunction

  assign tx_k = bit_position_next - n_cmd;
  assign tx_word = WIDX'(tx_k >> 5);

  always_comb begin
    result.read_data = read_value;
    result.busy_flag = busy_next;
    result.chip_select_lines = polarity_bits_after() ^ {busy_next, 7'd0};
    result.sclk_pin = busy_next
      ? (cfg.clock_polarity ^ cfg.clock_phase ^ (tick_counter_next >= {1'b0, half}))
      : cfg.clock_polarity;
    result.mosi_pin = 1'b0;
    if (busy_next) begin
      if (bit_position_next < n_cmd) begin
        result.mosi_pin =
          opcode_word[cmd_bit_pos(bit_position_next[4:0], cfg.lsb_first)];
      end else if (tx_k < n_mosi) begin
        result.mosi_pin = data_words[tx_word][data_bit_pos(tx_k[4:0], cfg.lsb_first)];
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/spi_master_controller_top.sv @@
// Top level of the half-duplex SPI master controller: handshake and result register.
// Depends on smc_pkg, smc_request_if, smc_result_if, smc_cfg_if and smc_core.
//
// Each request on the request channel is one system tick of the peripheral. It may
// carry a bus write or read of the register words and always carries the sampled
// MISO level. For every request exactly one result comes back on the result
// channel: the bus read data (zero when no read) and the SCLK, MOSI, chip-select
// and busy levels after that tick.
// The result is registered and valid in the cycle after its request is accepted.
// Throughput is one request per cycle, set by the single result
// register; the request channel stays ready while that register is empty or is
// being drained in the same cycle, and drops ready only while a result is held.
// The cfg channel is always ready and writes clock divider, polarity, phase and
// bit order; write it only while no transfer is running.
// Reset (synchronous, active high) clears all register words, the bit counts and
// the engine, and leaves SCLK at its idle level.
// When the result receiver stalls, the result is held and no request is taken,
// so the serial engine does not advance either.
`default_nettype none

module spi_master_controller_top
  import smc_pkg::*;
#(
  parameter int DATA_WORDS = 8
) (
  input  wire logic    clk,
  input  wire logic    rst,
  smc_request_if.sink  request,
  smc_result_if.source result,
  smc_cfg_if.sink      cfg
);

  cfg_t cfg_regs;
  req_t req;
  res_t res_comb;
  res_t res_q;
  logic out_valid;
  logic accept;

  assign request.ready = !out_valid || result.ready;
  assign accept = request.valid && request.ready;
  assign cfg.ready = 1'b1;

  assign req.mode = request.mode;
  assign req.word_address = request.word_address;
  assign req.write_data = request.write_data;
  assign req.miso_pin = request.miso_pin;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_CLOCK_DIVIDER:  cfg_regs.clock_divider <= cfg.data[11:0];
        CFG_CLOCK_POLARITY: cfg_regs.clock_polarity <= cfg.data[0];
        CFG_CLOCK_PHASE:    cfg_regs.clock_phase <= cfg.data[0];
        CFG_LSB_FIRST:      cfg_regs.lsb_first <= cfg.data[0];
        default: ;
      endcase
    end
  end

  smc_core #(
    .DATA_WORDS(DATA_WORDS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (req),
    .cfg    (cfg_regs),
    .result (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res_comb;
    end
  end

  assign result.valid = out_valid;
  assign result.read_data = res_q.read_data;
  assign result.sclk_pin = res_q.sclk_pin;
  assign result.mosi_pin = res_q.mosi_pin;
  assign result.chip_select_lines = res_q.chip_select_lines;
  assign result.busy_flag = res_q.busy_flag;

endmodule

`default_nettype wire
